FILE: hdl/pga_pkg.sv
package pga_pkg;

   localparam int WORD_W    = 32;
   localparam int DIFF_W    = WORD_W + 1;
   localparam int PROD_W    = WORD_W + DIFF_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int RIDGE_W   = 2 * WORD_W;
   localparam int IDX_W     = 3;
   localparam int DIV_STEPS = WORD_W;
   localparam int DEN_W     = WORD_W + 1;
   localparam int REM_W     = DEN_W + 1;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_LOG_SUM = 2'd1,
      MODE_L1      = 2'd2,
      MODE_L2      = 2'd3
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_PENALTY_MODE     = 3'd0,
      CSR_PENALTY_LEVEL    = 3'd1,
      CSR_PROXIMITY_LEVEL  = 3'd2,
      CSR_PROXIMITY_ENABLE = 3'd3,
      CSR_CONSENSUS_LEVEL  = 3'd4,
      CSR_CONSENSUS_ENABLE = 3'd5
   } csr_index_type;

   typedef struct packed {
      mode_type penalty_mode;
      word_type penalty_level;
      word_type proximity_level;
      logic     proximity_enable;
      word_type consensus_level;
      logic     consensus_enable;
   } cfg_type;

   typedef struct packed {
      word_type param_value;
      word_type raw_gradient;
      word_type proximity_target;
      word_type consensus_value;
      word_type consensus_multiplier;
      logic     element_last;
   } req_payload_type;

   typedef struct packed {
      word_type adjusted_gradient;
      logic     last_out;
   } rsp_payload_type;

   // one element in flight after the proximity and consensus terms
   typedef struct packed {
      logic                       valid;
      word_type                   grad;
      word_type                   param;
      logic signed [RIDGE_W-1:0]  ridge;
      logic                       last;
   } item_type;

   function automatic word_type sat_word(input logic signed [SUM_W-1:0] x);
      logic [SUM_W-WORD_W:0] hi_bits;
      hi_bits = x[SUM_W-1:WORD_W-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         sat_word = x[WORD_W-1:0];
      end else if (x[SUM_W-1]) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: hdl/pga_stream_if.sv
interface pga_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/pga_csr.sv
module pga_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [pga_pkg::IDX_W-1:0]  csr_index,
   input  logic [pga_pkg::WORD_W-1:0] csr_write_data,
   output pga_pkg::cfg_type           cfg
);
   import pga_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PENALTY_MODE:     cfg_in.penalty_mode     = mode_type'(csr_write_data[1:0]);
            CSR_PENALTY_LEVEL:    cfg_in.penalty_level    = csr_write_data;
            CSR_PROXIMITY_LEVEL:  cfg_in.proximity_level  = csr_write_data;
            CSR_PROXIMITY_ENABLE: cfg_in.proximity_enable = csr_write_data[0];
            CSR_CONSENSUS_LEVEL:  cfg_in.consensus_level  = csr_write_data;
            CSR_CONSENSUS_ENABLE: cfg_in.consensus_enable = csr_write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/pga_terms.sv
module pga_terms #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  pga_pkg::req_payload_type in_data,
   input  pga_pkg::cfg_type         cfg,
   output pga_pkg::item_type        out_item
);
   import pga_pkg::*;

   typedef struct packed {
      logic                      valid;
      word_type                  param;
      word_type                  grad;
      word_type                  mult;
      logic signed [DIFF_W-1:0]  prox_diff;
      logic signed [DIFF_W-1:0]  cons_diff;
      logic                      last;
   } diff_stage_type;

   typedef struct packed {
      logic                       valid;
      word_type                   param;
      word_type                   grad;
      word_type                   mult;
      logic signed [PROD_W-1:0]   prox_prod;
      logic signed [PROD_W-1:0]   cons_prod;
      logic signed [RIDGE_W-1:0]  ridge_prod;
      logic                       last;
   } prod_stage_type;

   typedef struct packed {
      logic                       valid;
      word_type                   param;
      word_type                   grad;
      logic signed [SUM_W-1:0]    cons_sum;
      logic signed [RIDGE_W-1:0]  ridge;
      logic                       last;
   } prox_stage_type;

   diff_stage_type diff_ff, diff_in;
   prod_stage_type prod_ff, prod_in;
   prox_stage_type prox_ff, prox_in;
   item_type       item_ff, item_in;

   logic signed [PROD_W-1:0] prox_term;
   logic signed [PROD_W-1:0] cons_term;

   // differences kept exact in one extra bit
   always_comb begin
      diff_in.valid     = in_valid;
      diff_in.param     = in_data.param_value;
      diff_in.grad      = in_data.raw_gradient;
      diff_in.mult      = in_data.consensus_multiplier;
      diff_in.prox_diff = DIFF_W'(in_data.param_value) - DIFF_W'(in_data.proximity_target);
      diff_in.cons_diff = DIFF_W'(in_data.param_value) - DIFF_W'(in_data.consensus_value);
      diff_in.last      = in_data.element_last;
   end

   always_comb begin
      prod_in.valid      = diff_ff.valid;
      prod_in.param      = diff_ff.param;
      prod_in.grad       = diff_ff.grad;
      prod_in.mult       = diff_ff.mult;
      prod_in.prox_prod  = PROD_W'(cfg.proximity_level) * PROD_W'(diff_ff.prox_diff);
      prod_in.cons_prod  = PROD_W'(cfg.consensus_level) * PROD_W'(diff_ff.cons_diff);
      prod_in.ridge_prod = RIDGE_W'(cfg.penalty_level) * RIDGE_W'(diff_ff.param);
      prod_in.last       = diff_ff.last;
   end

   // arithmetic shift is the floor scaling
   always_comb begin
      prox_term        = prod_ff.prox_prod >>> FRAC_BITS;
      cons_term        = prod_ff.cons_prod >>> FRAC_BITS;
      prox_in.valid    = prod_ff.valid;
      prox_in.param    = prod_ff.param;
      if (cfg.proximity_enable && (cfg.proximity_level != '0)) begin
         prox_in.grad = sat_word(SUM_W'(prod_ff.grad) + SUM_W'(prox_term));
      end else begin
         prox_in.grad = prod_ff.grad;
      end
      prox_in.cons_sum = SUM_W'(cons_term) + SUM_W'(prod_ff.mult);
      prox_in.ridge    = prod_ff.ridge_prod >>> FRAC_BITS;
      prox_in.last     = prod_ff.last;
   end

   always_comb begin
      item_in.valid = prox_ff.valid;
      item_in.param = prox_ff.param;
      if (cfg.consensus_enable) begin
         item_in.grad = sat_word(SUM_W'(prox_ff.grad) + prox_ff.cons_sum);
      end else begin
         item_in.grad = prox_ff.grad;
      end
      item_in.ridge = prox_ff.ridge;
      item_in.last  = prox_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff.valid <= 1'b0;
         prod_ff.valid <= 1'b0;
         prox_ff.valid <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         prox_ff <= prox_in;
         item_ff <= item_in;
      end
   end

   assign out_item = item_ff;

endmodule

FILE: hdl/pga_div.sv
module pga_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  pga_pkg::item_type          in_item,
   input  pga_pkg::word_type          penalty_level,
   output pga_pkg::item_type          out_item,
   output logic [pga_pkg::WORD_W-1:0] quotient
);
   import pga_pkg::*;

   localparam int LAST_STEP = DIV_STEPS - 1;

   // restoring divider, one quotient bit per stage:
   // |level| * 2^FRAC_BITS / (2^FRAC_BITS + |param|)
   item_type          item_ff [DIV_STEPS];
   logic [REM_W-1:0]  rem_ff  [DIV_STEPS];
   logic [WORD_W-1:0] num_ff  [DIV_STEPS];
   logic [DEN_W-1:0]  den_ff  [DIV_STEPS];

   logic [WORD_W-1:0]   mag;
   logic [WORD_W-1:0]   abs_param;
   logic [2*WORD_W-1:0] numer;

   always_comb begin
      mag       = penalty_level[WORD_W-1] ? -penalty_level : penalty_level;
      abs_param = in_item.param[WORD_W-1] ? -in_item.param : in_item.param;
      numer     = {{WORD_W{1'b0}}, mag} << FRAC_BITS;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      item_type          item_src;
      logic [REM_W-1:0]  rem_src;
      logic [WORD_W-1:0] num_src;
      logic [DEN_W-1:0]  den_src;
      logic [REM_W-1:0]  trial;
      logic              fits;

      if (k == 0) begin : g_first
         // upper numerator bits already sit below the divisor
         assign item_src = in_item;
         assign rem_src  = REM_W'(numer[2*WORD_W-1:WORD_W]);
         assign num_src  = numer[WORD_W-1:0];
         assign den_src  = (DEN_W'(1) << FRAC_BITS) + DEN_W'(abs_param);
      end else begin : g_next
         assign item_src = item_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign num_src  = num_ff[k-1];
         assign den_src  = den_ff[k-1];
      end

      assign trial = {rem_src[REM_W-2:0], num_src[WORD_W-1]};
      assign fits  = trial >= REM_W'(den_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            item_ff[k].valid <= 1'b0;
         end else if (advance) begin
            item_ff[k] <= item_src;
            rem_ff[k]  <= fits ? trial - REM_W'(den_src) : trial;
            num_ff[k]  <= {num_src[WORD_W-2:0], fits};
            den_ff[k]  <= den_src;
         end
      end
   end

   assign out_item = item_ff[LAST_STEP];
   assign quotient = num_ff[LAST_STEP];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      item_ff[LAST_STEP].valid |-> rem_ff[LAST_STEP] < REM_W'(den_ff[LAST_STEP]))
      else $error("divider remainder not below divisor");

endmodule

FILE: hdl/pga_out.sv
module pga_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  pga_pkg::item_type          in_item,
   input  logic [pga_pkg::WORD_W-1:0] quotient,
   input  pga_pkg::cfg_type           cfg,
   output logic                       rsp_valid,
   output pga_pkg::rsp_payload_type   rsp_data
);
   import pga_pkg::*;

   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic signed [SUM_W-1:0] grad_w;
   logic signed [SUM_W-1:0] level_w;
   logic signed [SUM_W-1:0] mag_w;
   logic signed [SUM_W-1:0] quot_w;
   logic signed [SUM_W-1:0] soft_w;
   logic signed [SUM_W-1:0] log_sum_w;
   logic signed [SUM_W-1:0] l1_w;
   logic signed [SUM_W-1:0] ridge_w;
   logic signed [SUM_W-1:0] pick_w;
   logic                    param_pos;
   logic                    param_zero;

   always_comb begin
      grad_w     = SUM_W'(in_item.grad);
      level_w    = SUM_W'(cfg.penalty_level);
      mag_w      = level_w[SUM_W-1] ? -level_w : level_w;
      quot_w     = level_w[SUM_W-1] ? -SUM_W'(quotient) : SUM_W'(quotient);
      param_zero = (in_item.param == '0);
      param_pos  = !in_item.param[WORD_W-1] && !param_zero;

      // soft threshold toward zero at a zero parameter
      if (grad_w > 0) begin
         soft_w = (grad_w <= mag_w) ? '0 : grad_w - mag_w;
      end else if (grad_w < 0) begin
         soft_w = (grad_w >= -mag_w) ? '0 : grad_w + mag_w;
      end else begin
         soft_w = '0;
      end

      log_sum_w = param_pos ? grad_w + quot_w : grad_w - quot_w;
      l1_w      = param_pos ? grad_w + level_w : grad_w - level_w;
      ridge_w   = grad_w + SUM_W'(in_item.ridge);

      pick_w = grad_w;
      if (cfg.penalty_level != '0) begin
         case (cfg.penalty_mode)
            MODE_NONE:    pick_w = grad_w;
            MODE_LOG_SUM: pick_w = param_zero ? soft_w : log_sum_w;
            MODE_L1:      pick_w = param_zero ? soft_w : l1_w;
            MODE_L2:      pick_w = ridge_w;
            default:      pick_w = grad_w;
         endcase
      end

      rsp_data_in.adjusted_gradient = sat_word(pick_w);
      rsp_data_in.last_out          = in_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_item.valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/penalized_gradient_adjust.sv
// throughput: one element beat per cycle while no result is held at the output
// path: an accepted element passes four term stages,
// 32 stages of the bit-per-stage divider and the output register
// the whole pipeline advances together and holds while a result waits at the output
// reset is synchronous: all valid bits drop and every config register returns to 0
module penalized_gradient_adjust #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   pga_stream_if.sink                 req_bus,
   pga_stream_if.source               rsp_bus,
   input  logic                       csr_write_en,
   input  logic [pga_pkg::IDX_W-1:0]  csr_index,
   input  logic [pga_pkg::WORD_W-1:0] csr_write_data
);
   import pga_pkg::*;

   cfg_type         cfg;
   item_type        terms_item;
   item_type        div_item;
   logic [WORD_W-1:0] quotient;
   logic            advance;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   // a held result stalls every stage behind it
   assign advance       = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;

   pga_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   pga_terms #(.FRAC_BITS(FRAC_BITS)) u_terms (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_bus.valid),
      .in_data  (req_bus.payload),
      .cfg      (cfg),
      .out_item (terms_item)
   );

   pga_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_item       (terms_item),
      .penalty_level (cfg.penalty_level),
      .out_item      (div_item),
      .quotient      (quotient)
   );

   pga_out u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_item   (div_item),
      .quotient  (quotient),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.valid   = rsp_valid;
   assign rsp_bus.payload = rsp_data;

   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while the output is stalled");

   a_idle_out_follows_pipe: assert property (@(posedge clock) disable iff (reset)
      (advance && !div_item.valid) |=> !rsp_bus.valid)
      else $error("result beat without an element in the last stage");

endmodule
